@@ rtl/core/rf_code_switch_table_top_macros.svh @@
// Assertion macros for the switch table checker.
`ifndef RF_CODE_SWITCH_TABLE_TOP_MACROS_SVH
`define RF_CODE_SWITCH_TABLE_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define RFCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("switch table assertion failed");

// Next-cycle implication, off during reset.
`define RFCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("switch table assertion failed");

// Next-cycle implication that also covers reset.
`define RFCS_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("switch table reset assertion failed");

`endif

@@ rtl/core/rfcs_pkg.sv @@
package rfcs_pkg;

  localparam int NUM_SWITCHES_DEF = 16;
  localparam int MAX_RESULTS = 16;
  localparam logic [15:0] REPEAT_WINDOW_RST = 16'd1000;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CODE = 1'b1;

  localparam logic KIND_ONOFF = 1'b0;
  localparam logic KIND_TOGGLE = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  slot;
    logic [23:0] on_code;
    logic [23:0] off_code;
    logic        switch_kind;
    logic        active_in;
    logic [23:0] rx_code;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [3:0]  changed_slot;
    logic        new_active;
    logic [23:0] matched_code;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [23:0] on_code;
    logic [23:0] off_code;
    logic        kind;
    logic        active;
  } entry_t;

endpackage

@@ rtl/core/rfcs_table.sv @@
module rfcs_table #(
  parameter int NUM_SWITCHES = rfcs_pkg::NUM_SWITCHES_DEF,
  parameter int IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  rfcs_pkg::entry_t    wdata,
  input  logic                re,
  input  logic [IDX_W-1:0]    raddr,
  output rfcs_pkg::entry_t    rdata
);
  import rfcs_pkg::*;

  entry_t                  mem [NUM_SWITCHES];
  logic [NUM_SWITCHES-1:0] vld_r;
  entry_t                  rdata_r;
  logic                    rvld_r;

  // Unwritten entries read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) vld_r[waddr] <= 1'b1;
      if (re) rvld_r <= vld_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

@@ rtl/core/rf_code_switch_table_top.sv @@
// Remote switch table. A write item leaves busy low. A received code that is dropped
// by the repeat filter, or is zero, also leaves busy low. Any other code walks the
// table one entry per cycle through the table memory's read port, so busy stays high,
// and no new item is accepted, until the walk is done. Results come out at most one
// per cycle, each for a single cycle on out_strobe, and must be taken as they appear;
// the final one of a code carries last and appears in the cycle in which busy falls.
module rf_code_switch_table_top #(
  parameter int NUM_SWITCHES = rfcs_pkg::NUM_SWITCHES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata,
  input  logic           start,
  input  rfcs_pkg::in_t  in_data,
  output logic           busy,
  output logic           out_strobe,
  output rfcs_pkg::out_t out_data
);
  import rfcs_pkg::*;

  localparam int IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;
  localparam int CNT_W = $clog2(NUM_SWITCHES + 1);
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic {ST_IDLE, ST_WALK} state_t;

  state_t           state_r;
  logic [15:0]      window_r;
  logic [23:0]      prev_code_r;
  logic [31:0]      prev_time_r;
  logic [23:0]      code_r;
  logic [CNT_W-1:0] rd_cnt_r;
  logic             eval_vld_r;
  logic [IDX_W-1:0] eval_idx_r;
  logic             pend_vld_r;
  out_t             pend_r;
  logic [RES_W-1:0] n_r;
  logic             out_strobe_r;
  out_t             out_r;

  logic             accept;
  logic             is_write;
  logic [31:0]      time_diff;
  logic             repeat_hit;
  logic             pass;
  logic             start_walk;
  logic             slot_ok;
  logic             rd_en;
  logic             walk_done;
  entry_t           ent;
  entry_t           new_ent;
  logic             chg;
  logic             act_new;
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr;
  entry_t           tbl_wdata;
  logic             take_res;
  logic             emit;

  assign accept     = start && (state_r == ST_IDLE);
  assign is_write   = (in_data.req_type == REQ_WRITE);
  assign time_diff  = in_data.now_ms - prev_time_r;
  assign repeat_hit = (in_data.rx_code == prev_code_r) && (time_diff < {16'd0, window_r});
  assign pass       = accept && !is_write && !repeat_hit;
  assign start_walk = pass && (in_data.rx_code != 24'd0);
  assign slot_ok    = ({28'd0, in_data.slot} < 32'(NUM_SWITCHES));
  assign rd_en      = (state_r == ST_WALK) && (rd_cnt_r != CNT_W'(NUM_SWITCHES));
  assign walk_done  = (state_r == ST_WALK) && (rd_cnt_r == CNT_W'(NUM_SWITCHES)) && !eval_vld_r;
  assign take_res   = (state_r == ST_WALK) && chg && (n_r != RES_W'(MAX_RESULTS));
  assign emit       = pend_vld_r && (take_res || walk_done);

  always_comb begin
    chg     = 1'b0;
    act_new = ent.active;
    if (ent.on_code == code_r) begin
      if (ent.kind == KIND_TOGGLE) begin
        act_new = ~ent.active;
        chg     = 1'b1;
      end else if (!ent.active) begin
        act_new = 1'b1;
        chg     = 1'b1;
      end
    end
    if (!chg && (ent.off_code == code_r) && (ent.kind == KIND_ONOFF) && ent.active) begin
      act_new = 1'b0;
      chg     = 1'b1;
    end
    chg = chg && eval_vld_r;
  end

  always_comb begin
    new_ent        = ent;
    new_ent.active = act_new;
  end

  always_comb begin
    if (state_r == ST_IDLE) begin
      tbl_we    = accept && is_write && slot_ok;
      tbl_waddr = IDX_W'(in_data.slot);
      tbl_wdata = '{on_code: in_data.on_code, off_code: in_data.off_code,
                    kind: in_data.switch_kind, active: in_data.active_in};
    end else begin
      tbl_we    = chg;
      tbl_waddr = eval_idx_r;
      tbl_wdata = new_ent;
    end
  end

  rfcs_table #(
    .NUM_SWITCHES(NUM_SWITCHES),
    .IDX_W(IDX_W)
  ) u_table (
    .clk(clk),
    .rst_n(rst_n),
    .we(tbl_we),
    .waddr(tbl_waddr),
    .wdata(tbl_wdata),
    .re(rd_en),
    .raddr(rd_cnt_r[IDX_W-1:0]),
    .rdata(ent)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      window_r     <= REPEAT_WINDOW_RST;
      prev_code_r  <= '0;
      prev_time_r  <= '0;
      rd_cnt_r     <= '0;
      eval_vld_r   <= 1'b0;
      pend_vld_r   <= 1'b0;
      n_r          <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= emit;
      if (emit) begin
        out_r <= '{changed_slot: pend_r.changed_slot, new_active: pend_r.new_active,
                   matched_code: pend_r.matched_code, last: walk_done};
      end
      if (cfg_we) window_r <= cfg_wdata;
      eval_vld_r <= rd_en;
      if (rd_en) begin
        eval_idx_r <= rd_cnt_r[IDX_W-1:0];
        rd_cnt_r   <= rd_cnt_r + CNT_W'(1);
      end
      case (state_r)
        ST_IDLE: begin
          if (pass) begin
            prev_code_r <= in_data.rx_code;
            prev_time_r <= in_data.now_ms;
          end
          if (start_walk) begin
            state_r    <= ST_WALK;
            code_r     <= in_data.rx_code;
            rd_cnt_r   <= '0;
            n_r        <= '0;
            pend_vld_r <= 1'b0;
          end
        end
        ST_WALK: begin
          // Hold one result back so the final one can be marked last.
          if (take_res) begin
            pend_r     <= '{changed_slot: 4'(eval_idx_r), new_active: act_new,
                            matched_code: code_r, last: 1'b0};
            pend_vld_r <= 1'b1;
            n_r        <= n_r + RES_W'(1);
          end
          if (walk_done) begin
            state_r    <= ST_IDLE;
            pend_vld_r <= 1'b0;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule

@@ rtl/core/rfcs_checker.sv @@
`include "rf_code_switch_table_top_macros.svh"

module rfcs_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input rfcs_pkg::in_t  in_data,
  input logic           out_strobe,
  input rfcs_pkg::out_t out_data
);
  import rfcs_pkg::*;

  logic acc_write;
  logic acc_zero;

  assign acc_write = start && !busy && (in_data.req_type == REQ_WRITE);
  assign acc_zero  = start && !busy && (in_data.req_type == REQ_CODE) && (in_data.rx_code == 24'd0);

  `RFCS_ASSERT_RST(a_reset_quiet, !rst_n, !busy && !out_strobe)
  `RFCS_ASSERT_NXT(a_write_no_busy, acc_write, !busy && !out_strobe)
  `RFCS_ASSERT_NXT(a_zero_no_result, acc_zero, !busy && !out_strobe)
  `RFCS_ASSERT_IMP(a_mid_while_busy, out_strobe && !out_data.last, busy)
  `RFCS_ASSERT_IMP(a_final_is_last, $fell(busy) && out_strobe, out_data.last)

endmodule

bind rf_code_switch_table_top rfcs_checker u_rfcs_checker (.*);

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rfcs_pkg::*;

  localparam int NSW = NUM_SWITCHES_DEF;
  localparam int DRAIN_CYCLES = NSW + 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE = 6;
  localparam int HALF_PHASE = 44;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        start = 1'b0;
  in_t         in_data = '0;
  logic        busy;
  logic        out_strobe;
  out_t        out_data;

  rf_code_switch_table_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // switch table state as the block should hold it
  entry_t      sw_table [NSW] = '{default: '0};
  logic [23:0] filt_code = '0;
  logic [31:0] filt_time = '0;
  logic [15:0] window_ms = REPEAT_WINDOW_RST;
  out_t        pending_changes[$];

  in_t         item_queue[$];
  logic        gaps_on = 1'b1;
  logic [23:0] code_pool [POOL_SIZE];
  logic [31:0] ms_clock = '0;
  logic [23:0] last_sent = '0;

  int errors = 0;
  int cycles = 0;
  int items_taken = 0;
  int codes_taken = 0;
  int codes_dropped = 0;
  int changes_seen = 0;

  task automatic switch_table_step(input in_t it);
    int   n;
    logic hit;
    logic have_held;
    out_t held;
    logic [31:0] age;
    n = 0;
    have_held = 1'b0;
    held = '0;
    if (it.req_type == REQ_WRITE) begin
      if (int'(it.slot) < NSW) begin
        sw_table[it.slot] = '{it.on_code, it.off_code, it.switch_kind, it.active_in};
      end
      return;
    end
    codes_taken++;
    age = it.now_ms - filt_time;
    if (it.rx_code == filt_code && age < 32'(window_ms)) begin
      codes_dropped++;
      return;
    end
    filt_code = it.rx_code;
    filt_time = it.now_ms;
    if (it.rx_code == '0) return;
    for (int i = 0; i < NSW; i++) begin
      hit = 1'b0;
      if (sw_table[i].on_code == it.rx_code) begin
        if (sw_table[i].kind == KIND_TOGGLE) begin
          sw_table[i].active = ~sw_table[i].active;
          hit = 1'b1;
        end else if (!sw_table[i].active) begin
          sw_table[i].active = 1'b1;
          hit = 1'b1;
        end
      end
      if (!hit && sw_table[i].off_code == it.rx_code && sw_table[i].kind == KIND_ONOFF &&
          sw_table[i].active) begin
        sw_table[i].active = 1'b0;
        hit = 1'b1;
      end
      if (hit && n < MAX_RESULTS) begin
        if (have_held) pending_changes.push_back(held);
        held = '{4'(i), sw_table[i].active, it.rx_code, 1'b0};
        have_held = 1'b1;
        n++;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      pending_changes.push_back(held);
    end
  endtask

  // driver: start is held until the item is taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        switch_table_step(in_data);
        items_taken++;
      end
      if (!(start && busy)) begin
        if (item_queue.size() > 0 && !(gaps_on && $urandom_range(0, 99) < 16)) begin
          start <= 1'b1;
          in_data <= item_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_mon
    out_t want;
    if (rst_n && out_strobe) begin
      if (pending_changes.size() == 0) begin
        $error("unexpected change: slot %0d active %0b code %0h",
               out_data.changed_slot, out_data.new_active, out_data.matched_code);
        errors++;
      end else begin
        want = pending_changes.pop_front();
        check_field("changed_slot", 32'(want.changed_slot), 32'(out_data.changed_slot));
        check_field("new_active", 32'(want.new_active), 32'(out_data.new_active));
        check_field("matched_code", 32'(want.matched_code), 32'(out_data.matched_code));
        check_field("last", 32'(want.last), 32'(out_data.last));
        changes_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_write(input logic [3:0] s, input logic [23:0] on_c, off_c,
                            input logic k, a);
    in_t it;
    it.req_type = REQ_WRITE;
    it.slot = s;
    it.on_code = on_c;
    it.off_code = off_c;
    it.switch_kind = k;
    it.active_in = a;
    it.rx_code = 24'($urandom);
    it.now_ms = $urandom;
    item_queue.push_back(it);
  endtask

  task automatic push_code(input logic [23:0] c, input logic [31:0] ms);
    in_t it;
    it.req_type = REQ_CODE;
    it.slot = 4'($urandom);
    it.on_code = 24'($urandom);
    it.off_code = 24'($urandom);
    it.switch_kind = 1'($urandom);
    it.active_in = 1'($urandom);
    it.rx_code = c;
    it.now_ms = ms;
    item_queue.push_back(it);
  endtask

  function automatic logic [23:0] pick_code();
    if ($urandom_range(0, 9) == 0) return 24'($urandom);
    return code_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'(window_ms) - 32'd1;
      2: return 32'(window_ms);
      3: return 32'(window_ms) + 32'd1;
      4: return $urandom;
      default: return $urandom_range(0, 32'(window_ms) * 2 + 4);
    endcase
  endfunction

  // mostly table loads followed by codes from the same pool, some raw noise
  task automatic gen_traffic(input int n);
    int          made;
    int          nw;
    int          nc;
    logic [23:0] on_c;
    logic [23:0] c;
    logic [127:0] raw;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 99) < 85) begin
        nw = $urandom_range(1, 4);
        nc = $urandom_range(1, 5);
        repeat (nw) begin
          on_c = pick_code();
          push_write(4'($urandom), on_c, ($urandom_range(0, 7) == 0) ? on_c : pick_code(),
                     1'($urandom), 1'($urandom));
        end
        repeat (nc) begin
          case ($urandom_range(0, 19))
            0: c = '0;
            1, 2, 3: c = last_sent;
            4, 5: c = 24'($urandom);
            default: c = code_pool[$urandom_range(0, POOL_SIZE - 1)];
          endcase
          ms_clock = ms_clock + pick_step();
          push_code(c, ms_clock);
          last_sent = c;
        end
        made += nw + nc;
      end else begin
        raw = {$urandom, $urandom, $urandom, $urandom};
        item_queue.push_back(raw[$bits(in_t)-1:0]);
        made++;
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (item_queue.size() > 0 || start || busy || pending_changes.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_window(input logic [15:0] w);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    window_ms = w;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] windows [5];
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // zero code right after reset repeats the cleared filter state
    push_code(24'h000000, 32'd0);
    for (int i = 0; i < NSW; i++) begin
      push_write(4'(i), 24'hFFFFFF, 24'h000001, KIND_TOGGLE, 1'(i));
    end
    push_code(24'hFFFFFF, 32'd5000);
    push_code(24'hFFFFFF, 32'd5999);
    push_code(24'hFFFFFF, 32'd6000);
    push_write(4'd15, 24'h000001, 24'h000001, KIND_ONOFF, 1'b0);
    push_code(24'h000001, 32'd7000);
    push_code(24'h000001, 32'd8000);
    push_code(24'h000000, 32'd8100);
    push_code(24'hFFFFFF, 32'hFFFF_FF00);
    push_code(24'hFFFFFF, 32'h0000_0100);
    wait_idle();

    windows = '{16'd0, 16'hFFFF, 16'($urandom_range(2, 5000)), 16'd1, REPEAT_WINDOW_RST};
    for (int p = 0; p < 5; p++) begin
      write_window(windows[p]);
      gaps_on = (p != 2);
      for (int i = 0; i < POOL_SIZE; i++) code_pool[i] = 24'($urandom);
      ms_clock = 32'hFFFF_FFFF - $urandom_range(0, 200000);
      for (int h = 0; h < 2; h++) begin
        gen_traffic(HALF_PHASE);
        wait_idle();
      end
    end

    $display("Ran %0d items (%0d codes, %0d dropped as repeats), checked %0d switch changes",
             items_taken, codes_taken, codes_dropped, changes_seen);
    $display("Repeat windows used: 1000, 0, 65535, %0d, 1, 1000", windows[2]);
    if (errors == 0 && pending_changes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/rfcs_pkg.sv
rtl/core/rfcs_table.sv
rtl/core/rf_code_switch_table_top.sv
rtl/core/rfcs_checker.sv
tb/tb.sv
